[src/kaf_pkg.sv]
// ----------------------------------------------------------------------------
// kaf_pkg
// Shared types and constants for the angle/bias Kalman fusion block.
// ----------------------------------------------------------------------------
package kaf_pkg;

   localparam int FracBits = 28;

   localparam logic [1:0] CSR_DT = 2'd0;
   localparam logic [1:0] CSR_R  = 2'd1;
   localparam logic [1:0] CSR_QA = 2'd2;
   localparam logic [1:0] CSR_QG = 2'd3;

   localparam logic [30:0] DT_RESET = 31'd5368709;
   localparam logic [30:0] R_RESET  = 31'd134217728;
   localparam logic [30:0] QA_RESET = 31'd26844;
   localparam logic [30:0] QG_RESET = 31'd80531;
   localparam logic signed [31:0] ONE_Q28 = 32'sd268435456;

   // divider handshake
   typedef struct packed {
      logic        start;
      logic signed [31:0] num;
      logic [32:0] den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic signed [31:0] quo;
   } div_rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // floor((v + 2^27) / 2^28), arithmetic shift does the floor
   function automatic logic signed [63:0] rnd_q28(input logic signed [63:0] v);
      logic signed [63:0] s;
      s = v + 64'sd134217728;
      return s >>> FracBits;
   endfunction

endpackage

[src/kaf_divider.sv]
// ----------------------------------------------------------------------------
// kaf_divider
// Restoring divider, one quotient bit per cycle: (num << 28) / den,
// truncated toward zero, saturated to 32 bits. den is positive.
// ----------------------------------------------------------------------------
module kaf_divider import kaf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [59:0] dividend_ff, dividend_in;
   logic [32:0] rem_ff, rem_in;
   logic [32:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [59:0] quo_ff, quo_in;
   logic [33:0] trial;
   logic [31:0] mag;
   logic signed [63:0] sq;

   always_comb begin
      dividend_in = dividend_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      quo_in = quo_ff;
      mag = req.num[31] ? 32'(-req.num) : req.num;
      // the remainder stays below den, so 33 bits hold it
      trial = {rem_ff, dividend_ff[59]} - {1'b0, den_ff};
      if (req.start) begin
         dividend_in = {mag, 28'd0};
         rem_in = '0;
         den_in = req.den;
         neg_in = req.num[31];
         cnt_in = 6'd60;
         busy_in = 1'b1;
         quo_in = '0;
      end else if (busy_ff) begin
         dividend_in = {dividend_ff[58:0], 1'b0};
         if (!trial[33]) begin
            rem_in = trial[32:0];
            quo_in = {quo_ff[58:0], 1'b1};
         end else begin
            rem_in = {rem_ff[31:0], dividend_ff[59]};
            quo_in = {quo_ff[58:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      dividend_ff <= dividend_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      quo_ff <= quo_in;
   end

   assign sq = neg_ff ? -$signed({4'd0, quo_ff}) : $signed({4'd0, quo_ff});
   assign rsp.done = done_ff;
   assign rsp.quo = sat32(sq);

endmodule

[src/kaf_core.sv]
// ----------------------------------------------------------------------------
// kaf_core
// Sequencer around one shared 32x32 multiply-round unit and the divider.
// ----------------------------------------------------------------------------
module kaf_core import kaf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic signed [31:0] gyro,
   input  logic signed [31:0] meas,
   input  logic [30:0] dt,
   input  logic [30:0] r,
   input  logic [30:0] qa,
   input  logic [30:0] qg,
   output logic        done,
   output logic signed [31:0] angle,
   output logic signed [31:0] bias
);

   typedef enum logic [3:0] {
      S_IDLE, S_PROP, S_INNOV, S_DIV0, S_WAIT0, S_DIV1, S_WAIT1, S_UPD, S_DONE
   } state_type;

   state_type state_ff;
   logic [2:0] step_ff;
   logic signed [31:0] ang_ff, bia_ff, p00_ff, p01_ff, p10_ff, p11_ff;
   logic signed [31:0] rate_ff, pd0_ff, pd1_ff, err_ff, k0_ff, k1_ff;
   logic signed [31:0] y0_ff, y1_ff, meas_ff;
   logic        done_ff;
   logic signed [31:0] ma, mb, acc;
   logic signed [63:0] prod, rnd;
   logic        sub;
   div_req_type dreq;
   div_rsp_type drsp;
   logic signed [33:0] den;

   kaf_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   // shared multiplier operand select
   always_comb begin
      ma = rate_ff; mb = $signed({1'b0, dt}); acc = ang_ff; sub = 1'b0;
      if (state_ff == S_PROP) begin
         case (step_ff)
            3'd0: begin ma = rate_ff; acc = ang_ff; end
            3'd1: begin ma = pd0_ff; acc = p00_ff; end
            3'd2: begin ma = pd1_ff; acc = p01_ff; end
            3'd3: begin ma = pd1_ff; acc = p10_ff; end
            default: begin ma = $signed({1'b0, qg}); acc = p11_ff; end
         endcase
      end else begin
         sub = 1'b1;
         case (step_ff)
            3'd0: begin ma = k0_ff; mb = y0_ff; acc = p00_ff; end
            3'd1: begin ma = k0_ff; mb = y1_ff; acc = p01_ff; end
            3'd2: begin ma = k1_ff; mb = y0_ff; acc = p10_ff; end
            3'd3: begin ma = k1_ff; mb = y1_ff; acc = p11_ff; end
            3'd4: begin ma = k0_ff; mb = err_ff; acc = ang_ff; sub = 1'b0; end
            default: begin ma = k1_ff; mb = err_ff; acc = bia_ff; sub = 1'b0; end
         endcase
      end
   end

   assign prod = ma * mb;
   assign den = 34'($signed({1'b0, r})) + 34'(p00_ff);

   always_comb begin
      rnd = rnd_q28(prod);
      // propagation adds a saturated product
      if (state_ff == S_PROP) rnd = 64'(sat32(rnd));
   end

   always_comb begin
      dreq.start = (state_ff == S_DIV0) || (state_ff == S_DIV1);
      dreq.num = (state_ff == S_DIV0) ? p00_ff : p10_ff;
      dreq.den = (den <= 0) ? 33'd1 : den[32:0];
   end

   always_ff @(posedge clock) begin
      logic signed [31:0] res;
      res = sub ? sat32(64'(acc) - rnd) : sat32(64'(acc) + rnd);
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= '0;
         done_ff <= 1'b0;
         ang_ff <= '0; bia_ff <= '0;
         p00_ff <= ONE_Q28; p01_ff <= '0; p10_ff <= '0; p11_ff <= ONE_Q28;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (start) begin
               rate_ff <= sat32(64'(gyro) - 64'(bia_ff));
               pd0_ff <= sat32(64'($signed({1'b0, qa})) - 64'(p01_ff) - 64'(p10_ff));
               pd1_ff <= sat32(-64'(p11_ff));
               meas_ff <= meas;
               step_ff <= '0;
               state_ff <= S_PROP;
            end
            S_PROP: begin
               case (step_ff)
                  3'd0: ang_ff <= res;
                  3'd1: p00_ff <= res;
                  3'd2: p01_ff <= res;
                  3'd3: p10_ff <= res;
                  default: p11_ff <= res;
               endcase
               step_ff <= step_ff + 3'd1;
               if (step_ff == 3'd4) state_ff <= S_INNOV;
            end
            S_INNOV: begin
               err_ff <= sat32(64'(meas_ff) - 64'(ang_ff));
               state_ff <= S_DIV0;
            end
            S_DIV0: state_ff <= S_WAIT0;
            S_WAIT0: if (drsp.done) begin k0_ff <= drsp.quo; state_ff <= S_DIV1; end
            S_DIV1: state_ff <= S_WAIT1;
            S_WAIT1: if (drsp.done) begin
               k1_ff <= drsp.quo;
               y0_ff <= p00_ff; y1_ff <= p01_ff;
               step_ff <= '0;
               state_ff <= S_UPD;
            end
            S_UPD: begin
               case (step_ff)
                  3'd0: p00_ff <= res;
                  3'd1: p01_ff <= res;
                  3'd2: p10_ff <= res;
                  3'd3: p11_ff <= res;
                  3'd4: ang_ff <= res;
                  default: bia_ff <= res;
               endcase
               step_ff <= step_ff + 3'd1;
               if (step_ff == 3'd5) state_ff <= S_DONE;
            end
            S_DONE: begin done_ff <= 1'b1; state_ff <= S_IDLE; end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign angle = ang_ff;
   assign bias = bia_ff;

endmodule

[src/kalman_angle_fusion.sv]
// Two-state angle/gyro-bias Kalman filter. Each word takes 5 propagation and
// 6 update steps through a shared 32x32 multiplier, and two gain divisions in
// a bit-serial divider. req_stall stays high from acceptance until the result
// word has been taken.
// ----------------------------------------------------------------------------
// kalman_angle_fusion
// Top level: configuration registers, handshake and result register.
// ----------------------------------------------------------------------------
module kalman_angle_fusion import kaf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic signed [31:0] req_gyro_rate,
   input  logic signed [31:0] req_accel_angle,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [31:0] rsp_angle_estimate,
   output logic signed [31:0] rsp_bias_estimate,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [30:0] csr_data
);

   logic [30:0] dt_ff, r_ff, qa_ff, qg_ff;
   logic busy_ff, rsp_valid_ff;
   logic signed [31:0] ang_ff, bia_ff;
   logic done;
   logic signed [31:0] c_ang, c_bia;
   logic accept;

   assign accept = req_valid && !busy_ff;
   assign req_stall = busy_ff;

   kaf_core u_core (
      .clock(clock), .reset(reset), .start(accept),
      .gyro(req_gyro_rate), .meas(req_accel_angle),
      .dt(dt_ff), .r(r_ff), .qa(qa_ff), .qg(qg_ff),
      .done(done), .angle(c_ang), .bias(c_bia)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff <= DT_RESET; r_ff <= R_RESET; qa_ff <= QA_RESET; qg_ff <= QG_RESET;
         busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_DT: dt_ff <= csr_data;
               CSR_R:  r_ff <= csr_data;
               CSR_QA: qa_ff <= csr_data;
               default: qg_ff <= csr_data;
            endcase
         end
         if (accept) busy_ff <= 1'b1;
         if (done) begin
            rsp_valid_ff <= 1'b1;
            ang_ff <= c_ang;
            bia_ff <= c_bia;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
            busy_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_angle_estimate = ang_ff;
   assign rsp_bias_estimate = bia_ff;

endmodule

[src/kaf_checker.sv]
// ----------------------------------------------------------------------------
// kaf_checker
// Port-level checks for the fusion block.
// ----------------------------------------------------------------------------
module kaf_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic [31:0] rsp_angle_estimate
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_angle_estimate))
      else $error("result word dropped or changed under stall");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("accepted word did not block input");

   a_out_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while result pending");

   a_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind kalman_angle_fusion kaf_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_angle_estimate(rsp_angle_estimate)
);

[tb/kalman_angle_fusion_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kalman_angle_fusion_checker
// Watches the request, response and register-write ports of the angle/bias
// Kalman filter, predicts each response word and compares it field by field.
// ----------------------------------------------------------------------------
module kalman_angle_fusion_checker import kaf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic signed [31:0] req_gyro_rate,
   input  logic signed [31:0] req_accel_angle,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic signed [31:0] rsp_angle_estimate,
   input  logic signed [31:0] rsp_bias_estimate,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [30:0] csr_data,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic signed [31:0] angle;
      logic signed [31:0] bias;
   } estimate_type;

   estimate_type estimate_q[$];

   logic [30:0] dt_reg, r_reg, qa_reg, qg_reg;
   logic signed [31:0] angle_st, bias_st, p00, p01, p10, p11;

   function automatic logic signed [31:0] clip(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // add half an LSB, then floor
   function automatic logic signed [63:0] round28(input logic signed [63:0] v);
      logic signed [63:0] s;
      s = v + 64'sd134217728;
      return s >>> 28;
   endfunction

   function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b);
      return clip(round28(p));
   endfunction

   function automatic logic signed [31:0] addq(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      return clip(64'(a) + 64'(b));
   endfunction

   function automatic logic signed [31:0] divq(input logic signed [31:0] num,
                                               input logic signed [63:0] den);
      logic signed [63:0] n;
      n = 64'(num) <<< 28;
      return clip(n / den);
   endfunction

   task automatic filter_update(input logic signed [31:0] gyro,
                                input logic signed [31:0] meas);
      logic signed [31:0] dtq, rate, d0, d1, d3, innov, k0, k1, y0, y1;
      logic signed [63:0] den;
      estimate_type e;
      dtq   = $signed({1'b0, dt_reg});
      rate  = clip(64'(gyro) - 64'(bias_st));
      d0    = clip(64'($signed({1'b0, qa_reg})) - 64'(p01) - 64'(p10));
      d1    = clip(-64'(p11));
      d3    = $signed({1'b0, qg_reg});
      angle_st = addq(angle_st, mulq(rate, dtq));
      p00   = addq(p00, mulq(d0, dtq));
      p01   = addq(p01, mulq(d1, dtq));
      p10   = addq(p10, mulq(d1, dtq));
      p11   = addq(p11, mulq(d3, dtq));
      innov = clip(64'(meas) - 64'(angle_st));
      den   = 64'($signed({1'b0, r_reg})) + 64'(p00);
      if (den <= 0) den = 1;
      k0 = divq(p00, den);
      k1 = divq(p10, den);
      y0 = p00;
      y1 = p01;
      p00 = clip(64'(p00) - round28(64'(k0) * 64'(y0)));
      p01 = clip(64'(p01) - round28(64'(k0) * 64'(y1)));
      p10 = clip(64'(p10) - round28(64'(k1) * 64'(y0)));
      p11 = clip(64'(p11) - round28(64'(k1) * 64'(y1)));
      angle_st = clip(64'(angle_st) + round28(64'(k0) * 64'(innov)));
      bias_st  = clip(64'(bias_st) + round28(64'(k1) * 64'(innov)));
      e.angle = angle_st;
      e.bias  = bias_st;
      estimate_q.push_back(e);
   endtask

   task automatic report(input string what, input logic signed [31:0] got,
                         input logic signed [31:0] want);
      $display("%0t mismatch %s: got %0d, want %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      estimate_type e;
      if (reset) begin
         dt_reg = DT_RESET;
         r_reg = R_RESET;
         qa_reg = QA_RESET;
         qg_reg = QG_RESET;
         angle_st = '0;
         bias_st = '0;
         p00 = ONE_Q28;
         p01 = '0;
         p10 = '0;
         p11 = ONE_Q28;
         estimate_q.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_DT: dt_reg = csr_data;
               CSR_R:  r_reg = csr_data;
               CSR_QA: qa_reg = csr_data;
               CSR_QG: qg_reg = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) filter_update(req_gyro_rate, req_accel_angle);
         if (rsp_valid && !rsp_stall) begin
            if (estimate_q.size() == 0) begin
               $display("%0t unexpected response word", $realtime);
               fail_count++;
            end else begin
               e = estimate_q.pop_front();
               if (rsp_angle_estimate !== e.angle)
                  report("angle_estimate", rsp_angle_estimate, e.angle);
               if (rsp_bias_estimate !== e.bias)
                  report("bias_estimate", rsp_bias_estimate, e.bias);
            end
         end
      end
      pending = estimate_q.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
   end

endmodule

[tb/kalman_angle_fusion_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kalman_angle_fusion_tb
// Drives directed and random gyro/accelerometer words through several filter
// settings with random idling on both sides; the checker predicts each result.
// ----------------------------------------------------------------------------
module kalman_angle_fusion_tb import kaf_pkg::*; ();

   localparam int CycleLimit = 1_500_000;
   localparam int DrainCycles = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_gyro_rate = '0;
   logic signed [31:0] req_accel_angle = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_angle_estimate, rsp_bias_estimate;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = CSR_DT;
   logic [30:0] csr_data = '0;
   int fail_count, pending;
   int cycle_count = 0;
   bit calm = 1'b0;
   int hold_off = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   kalman_angle_fusion u_top (.*);

   kalman_angle_fusion_checker u_checker (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver stall: random bursts, or a long hold-off when requested
   initial begin
      int n;
      @(negedge reset);
      forever begin
         if (hold_off > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_off) @(posedge clock);
            hold_off = 0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 9);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic send_word(input logic signed [31:0] gyro,
                            input logic signed [31:0] meas);
      int n;
      if (!calm && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 9);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_gyro_rate <= gyro;
      req_accel_angle <= meas;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic logic signed [31:0] small_val();
      return $signed(32'($urandom_range(0, 2_000_000))) - 32'sd1_000_000;
   endfunction

   initial begin
      logic signed [31:0] ext [4];
      ext = '{32'sh7fffffff, 32'sh80000000, 32'sd0, -32'sd1};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes at reset settings
      foreach (ext[i]) foreach (ext[j]) send_word(ext[i], ext[j]);
      send_word(32'sh55555555, 32'shaaaaaaaa);
      req_valid <= 1'b0;
      wait_idle();

      // extreme settings: zero period and process noise with minimum measurement noise, then full-scale everything
      write_reg(CSR_DT, 31'd0);
      write_reg(CSR_R, 31'd1);
      write_reg(CSR_QA, 31'd0);
      write_reg(CSR_QG, 31'd0);
      repeat (3) send_word($urandom, $urandom);
      req_valid <= 1'b0;
      wait_idle();
      write_reg(CSR_DT, 31'h7fffffff);
      write_reg(CSR_R, 31'h7fffffff);
      write_reg(CSR_QA, 31'h7fffffff);
      write_reg(CSR_QG, 31'h7fffffff);
      repeat (4) send_word($urandom, $urandom);
      req_valid <= 1'b0;
      wait_idle();

      // random phases with random or typical settings
      for (int ph = 0; ph < 10; ph++) begin
         if (ph % 2 == 0) begin
            write_reg(CSR_DT, 31'($urandom_range(1, 27_000_000)));
            write_reg(CSR_R, 31'($urandom_range(1, 600_000_000)));
            write_reg(CSR_QA, 31'($urandom_range(0, 300_000)));
            write_reg(CSR_QG, 31'($urandom_range(0, 300_000)));
         end else begin
            write_reg(CSR_DT, 31'($urandom));
            write_reg(CSR_R, 31'($urandom));
            write_reg(CSR_QA, 31'($urandom));
            write_reg(CSR_QG, 31'($urandom));
         end
         if (ph == 3) hold_off = 2000;
         if (ph == 9) calm = 1'b1;
         for (int k = 0; k < 100; k++) begin
            if ($urandom_range(0, 3) == 0) send_word($urandom, $urandom);
            else send_word(small_val(), small_val());
         end
         req_valid <= 1'b0;
         wait_idle();
      end

      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
